FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared definitions for the fixed-point ALU
// Command codes, status codes, work kinds and the record passed between the
// front and back parts of the ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  // Quotient magnitude never exceeds 2^30, so 31 quotient bits always suffice.
  localparam int unsigned QW = 31;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_MIN      = 4'd6,
    CMD_MAX      = 4'd7,
    CMD_ABS      = 4'd8,
    CMD_FROM_INT = 4'd9,
    CMD_TO_INT   = 4'd10
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        res;
    logic [1:0]         status;
    logic               lt;
    logic               eq;
    logic               gt;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [QW-1:0]      num;
    logic [31:0]        den;
    logic               qneg;
  } rec_t;

endpackage
`default_nettype wire

FILE: rtl/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted push writes the queue, then the item passes the multiplier
//   stage, 31 divider stages and the sign stage before it shows on the output
//   ports.
// Throughput: one item per cycle while the output is free or popped, set by the
//   fully pipelined 32x32 multiplier and the one-bit-per-stage divider; every command takes the same path.
// Reset: synchronous, active low; clears the queue pointers and all stage
//   valid bits, so the block comes up empty and not full.
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8: signed fixed-point ALU
// Front part classifies items and finishes the simple commands, a short queue
// decouples it from the back pipeline that does multiply and divide.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH   = fpa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [3:0]  in_command,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_result_value,
  output logic [1:0]       out_status,
  output logic             out_a_less,
  output logic             out_a_equal,
  output logic             out_a_greater
);

  localparam int unsigned RW = $bits(fpa_pkg::rec_t);

  fpa_pkg::rec_t front_rec;
  fpa_pkg::rec_t head_rec;
  logic [RW-1:0] head_bits;
  logic          head_valid;
  logic          head_take;
  logic          res_valid;

  // Every item is classified in the cycle it is pushed; commands that need
  // no multiply or divide already carry their final result in the record.
  fpa_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .command  (in_command),
    .operand_a(in_operand_a),
    .operand_b(in_operand_b),
    .rec      (front_rec)
  );

  // The queue lets the input side keep accepting items while the output
  // side is stalled, until it fills.
  fpa_fifo #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_rec),
    .full    (full),
    .rd_en   (head_take),
    .rd_data (head_bits),
    .rd_valid(head_valid)
  );

  assign head_rec = fpa_pkg::rec_t'(head_bits);

  // The back pipeline advances whenever its last stage is free or popped,
  // so items leave in the order they were pushed.
  fpa_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec         (head_rec),
    .rec_valid   (head_valid),
    .rec_take    (head_take),
    .result_value(out_result_value),
    .status      (out_status),
    .a_less      (out_a_less),
    .a_equal     (out_a_equal),
    .a_greater   (out_a_greater),
    .res_valid   (res_valid),
    .res_take    (pop)
  );

  assign empty = !res_valid;

  // Exactly one of the comparison flags is set on every result.
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("comparison flags not one-hot");

  // An error always comes with a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != fpa_pkg::ST_OK) |-> (out_result_value == 32'd0))
    else $error("nonzero result with error status");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == fpa_pkg::ST_OK || out_status == fpa_pkg::ST_OVF ||
                out_status == fpa_pkg::ST_DIVZ))
    else $error("undefined status code");

  // A pipeline that is not popped holds its result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_result_value)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

FILE: rtl/fpa_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_fifo: small register queue
// Holds classified items between the front and back parts of the ALU.
// ----------------------------------------------------------------------------
module fpa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  rd_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    rp_nxt  = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_nxt;
      if (do_rd) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

FILE: rtl/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front: item classifier
// Computes flags and the results of the simple commands, and prepares multiply and
// divide items for the back part.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  wire logic [3:0]  command,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output fpa_pkg::rec_t    rec
);

  localparam logic signed [63:0] BMAX = (64'sd1 <<< (31 - FRACTION_BITS)) - 64'sd1;
  localparam logic signed [63:0] BMIN = -(64'sd1 <<< (31 - FRACTION_BITS));

  logic signed [31:0] a, b;
  logic signed [63:0] a64, b64, sum, dif, num64, nmag;

  always_comb begin
    a     = operand_a;
    b     = operand_b;
    a64   = {{32{a[31]}}, a};
    b64   = {{32{b[31]}}, b};
    sum   = a64 + b64;
    dif   = a64 - b64;
    num64 = a64 <<< FRACTION_BITS;
    nmag  = num64[63] ? -num64 : num64;

    rec        = '0;
    rec.kind   = fpa_pkg::KIND_DONE;
    rec.status = fpa_pkg::ST_OK;
    rec.a      = a;
    rec.b      = b;
    rec.lt     = (a < b);
    rec.eq     = (a == b);
    rec.gt     = (a > b);
    rec.num    = nmag[fpa_pkg::QW-1:0];
    rec.den    = b[31] ? 32'(-b) : 32'(b);
    rec.qneg   = a[31] ^ b[31];

    case (fpa_pkg::cmd_t'(command))
      fpa_pkg::CMD_ADD: begin
        if (sum > BMAX || sum < BMIN) rec.status = fpa_pkg::ST_OVF;
        else rec.res = sum[31:0];
      end
      fpa_pkg::CMD_SUB: begin
        if (dif > BMAX || dif < BMIN) rec.status = fpa_pkg::ST_OVF;
        else rec.res = dif[31:0];
      end
      fpa_pkg::CMD_MUL: begin
        rec.kind = fpa_pkg::KIND_MUL;
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 32'sd0) rec.status = fpa_pkg::ST_DIVZ;
        else if (num64 > BMAX || num64 < BMIN) rec.status = fpa_pkg::ST_OVF;
        else rec.kind = fpa_pkg::KIND_DIV;
      end
      fpa_pkg::CMD_INC: begin
        if (a64 + 64'sd1 > BMAX) rec.status = fpa_pkg::ST_OVF;
        else rec.res = 32'(a + 32'sd1);
      end
      fpa_pkg::CMD_DEC: begin
        if (a64 - 64'sd1 < BMIN) rec.status = fpa_pkg::ST_OVF;
        else rec.res = 32'(a - 32'sd1);
      end
      fpa_pkg::CMD_MIN: rec.res = (a < b) ? a : b;
      fpa_pkg::CMD_MAX: rec.res = (a > b) ? a : b;
      fpa_pkg::CMD_ABS: begin
        if (a64 < -BMAX) rec.status = fpa_pkg::ST_OVF;
        else rec.res = a[31] ? 32'(-a) : 32'(a);
      end
      fpa_pkg::CMD_FROM_INT: begin
        if (a64 > BMAX || a64 < BMIN) rec.status = fpa_pkg::ST_OVF;
        else rec.res = 32'(a <<< FRACTION_BITS);
      end
      fpa_pkg::CMD_TO_INT: rec.res = 32'(a >>> FRACTION_BITS);
      default: rec.res = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_back: multiply and divide pipeline
// A multiplier stage, one restoring-division stage per quotient bit and a
// final sign stage. The whole pipeline holds when its last stage is not taken.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  fpa_pkg::rec_t      rec,
  input  wire logic          rec_valid,
  output logic               rec_take,
  output logic [31:0]        result_value,
  output logic [1:0]         status,
  output logic               a_less,
  output logic               a_equal,
  output logic               a_greater,
  output logic               res_valid,
  input  wire logic          res_take
);

  localparam int unsigned NS = fpa_pkg::QW + 2;
  localparam logic signed [63:0] BMAX = (64'sd1 <<< (31 - FRACTION_BITS)) - 64'sd1;
  localparam logic signed [63:0] BMIN = -(64'sd1 <<< (31 - FRACTION_BITS));

  typedef struct packed {
    logic                   valid;
    fpa_pkg::kind_t         kind;
    logic [31:0]            res;
    logic [1:0]             status;
    logic                   lt;
    logic                   eq;
    logic                   gt;
    logic                   qneg;
    logic signed [63:0]     prod;
    logic [fpa_pkg::QW-1:0] num;
    logic [31:0]            den;
    logic [31:0]            rem;
    logic [fpa_pkg::QW-1:0] quo;
  } stg_t;

  stg_t stg_r   [NS];
  stg_t stg_nxt [NS];
  logic adv;

  // One restoring-division step: bring down the next dividend bit.
  function automatic stg_t div_step(input stg_t s);
    stg_t        o;
    logic [32:0] sh;
    logic        ge;
    o  = s;
    sh = {s.rem, s.num[fpa_pkg::QW-1]};
    ge = (sh >= {1'b0, s.den});
    o.rem = ge ? 32'(sh - {1'b0, s.den}) : sh[31:0];
    o.num = s.num << 1;
    o.quo = {s.quo[fpa_pkg::QW-2:0], ge};
    return o;
  endfunction

  assign adv      = !stg_r[NS-1].valid || res_take;
  assign rec_take = adv && rec_valid;

  always_comb begin
    stg_nxt[0].valid  = rec_valid;
    stg_nxt[0].kind   = rec.kind;
    stg_nxt[0].res    = rec.res;
    stg_nxt[0].status = rec.status;
    stg_nxt[0].lt     = rec.lt;
    stg_nxt[0].eq     = rec.eq;
    stg_nxt[0].gt     = rec.gt;
    stg_nxt[0].qneg   = rec.qneg;
    // Signed 32x32 product, sign-extended into the 64-bit field.
    stg_nxt[0].prod   = rec.a * rec.b;
    stg_nxt[0].num    = rec.num;
    stg_nxt[0].den    = rec.den;
    stg_nxt[0].rem    = '0;
    stg_nxt[0].quo    = '0;

    for (int k = 1; k < NS - 1; k++) begin
      stg_nxt[k] = div_step(stg_r[k-1]);
    end

    // The product is range-checked and scaled in the first division stage.
    if (stg_r[0].kind == fpa_pkg::KIND_MUL) begin
      if (stg_r[0].prod > BMAX || stg_r[0].prod < BMIN) begin
        stg_nxt[1].status = fpa_pkg::ST_OVF;
        stg_nxt[1].res    = '0;
      end else begin
        stg_nxt[1].res = 32'(stg_r[0].prod >>> FRACTION_BITS);
      end
    end

    stg_nxt[NS-1] = stg_r[NS-2];
    if (stg_r[NS-2].kind == fpa_pkg::KIND_DIV) begin
      stg_nxt[NS-1].res = stg_r[NS-2].qneg ? -{1'b0, stg_r[NS-2].quo}
                                           : {1'b0, stg_r[NS-2].quo};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        stg_r[k].valid <= 1'b0;
      end else if (adv) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign res_valid    = stg_r[NS-1].valid;
  assign result_value = stg_r[NS-1].res;
  assign status       = stg_r[NS-1].status;
  assign a_less       = stg_r[NS-1].lt;
  assign a_equal      = stg_r[NS-1].eq;
  assign a_greater    = stg_r[NS-1].gt;

endmodule
`default_nettype wire
